// ===== hdl/mdsd_pkg.sv =====
// shared types and constants for the multi-deck shuffle and draw block
package mdsd_pkg;

  // field widths
  localparam int CARD_W = 6;
  localparam int IDX_W  = 9;
  localparam int RAND_W = 31;
  localparam int KIND_W = 2;
  localparam int STAT_W = 3;
  localparam int LIM_W  = 8;
  localparam int RANK_W = 4;
  localparam int SUIT_W = 2;

  // cards per deck and ranks per suit
  localparam int DECK_CARDS = 52;
  localparam logic [RANK_W-1:0] RANK_FIRST = 4'd1;
  localparam logic [RANK_W-1:0] RANK_LAST  = 4'd13;

  // deal limit after reset
  localparam logic [LIM_W-1:0] DEAL_LIMIT_RST = 8'd255;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_RELOAD  = 2'd0,
    KIND_SHUFFLE = 2'd1,
    KIND_DRAW    = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_SHUFFLE_DONE = 3'd1,
    ST_EXHAUSTED    = 3'd2,
    ST_LIMIT        = 3'd3,
    ST_BAD_INDEX    = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FILL  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_RDB   = 7'b0001000,
    S_WR1   = 7'b0010000,
    S_WR2   = 7'b0100000,
    S_RDOUT = 7'b1000000
  } state_e;

endpackage

// ===== hdl/mdsd_ram.sv =====
// generic single write port ram with registered read
module mdsd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 416
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/multi_deck_shuffle_and_draw.sv =====
// multi-deck card store: reload, fisher-yates shuffle step, draw and read
// the modulo is a restoring divider doing one of 31 quotient bits per cycle
// one request at a time: busy stays high from acceptance until the result strobe;
// a refused request is answered without raising busy
// reset: asynchronous; afterwards busy is high while the ordered
// pattern is written into the card ram; done_o pulses one cycle and cannot be stalled
module multi_deck_shuffle_and_draw #(
  parameter int DECK_COUNT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mdsd_pkg::KIND_W-1:0]   kind_i,
  input  logic [mdsd_pkg::RAND_W-1:0]   random_value_i,
  input  logic [mdsd_pkg::IDX_W-1:0]    read_index_i,
  output logic                          done_o,
  output logic [mdsd_pkg::CARD_W-1:0]   card_o,
  output logic [mdsd_pkg::IDX_W-1:0]    position_o,
  output logic [mdsd_pkg::STAT_W-1:0]   status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mdsd_pkg::LIM_W-1:0]    cfg_data_i
);

  localparam int IW        = mdsd_pkg::IDX_W;
  localparam int RW        = mdsd_pkg::RAND_W;
  localparam int CW        = mdsd_pkg::CARD_W;
  localparam int TOTAL_INT = mdsd_pkg::DECK_CARDS * DECK_COUNT;
  localparam int AW        = $clog2(TOTAL_INT);
  localparam int BW        = $clog2(RW);
  localparam logic [IW-1:0] TOTAL    = IW'(TOTAL_INT);
  localparam logic [IW-1:0] TOP_IDX  = IW'(TOTAL_INT - 1);
  localparam logic [BW-1:0] LAST_BIT = BW'(RW - 1);

  mdsd_pkg::state_e  state_q, state_d;
  mdsd_pkg::kind_e   kind_q, kind_d;
  logic              reload_q, reload_d;
  logic [IW-1:0]     shuf_idx_q, shuf_idx_d;
  logic [IW-1:0]     drawn_q, drawn_d;
  logic [mdsd_pkg::LIM_W-1:0] limit_q;
  logic [IW-1:0]     fill_q, fill_d;
  logic [mdsd_pkg::RANK_W-1:0] rank_q, rank_d;
  logic [mdsd_pkg::SUIT_W-1:0] suit_q, suit_d;
  logic [RW-1:0]     dvd_q, dvd_d;
  logic [IW-1:0]     dvs_q, dvs_d;
  logic [IW-1:0]     rem_q, rem_d;
  logic [BW-1:0]     bit_q, bit_d;
  logic [CW-1:0]     card_a_q, card_a_d;
  logic              done_q, done_d;
  logic [CW-1:0]     card_q, card_d;
  logic [IW-1:0]     pos_q, pos_d;
  logic [mdsd_pkg::STAT_W-1:0] stat_q, stat_d;

  logic              accept;
  logic [IW:0]       trial;
  logic [IW:0]       trial_sub;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [CW-1:0]     ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [CW-1:0]     ram_rdata;

  assign accept      = start && (state_q == mdsd_pkg::S_IDLE);
  assign busy        = (state_q != mdsd_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign done_o     = done_q;
  assign card_o     = card_q;
  assign position_o = pos_q;
  assign status_o   = stat_q;

  // one restoring division step
  assign trial     = {rem_q, dvd_q[RW-1]};
  assign trial_sub = trial - {1'b0, dvs_q};

  // card ram
  mdsd_ram #(
    .WIDTH (CW),
    .DEPTH (TOTAL_INT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // read address: first operand is fetched while idle, the chosen slot later
  always_comb begin
    ram_raddr = rem_q;
    if (state_q == mdsd_pkg::S_IDLE) begin
      unique case (mdsd_pkg::kind_e'(kind_i))
        mdsd_pkg::KIND_SHUFFLE: ram_raddr = shuf_idx_q;
        mdsd_pkg::KIND_DRAW:    ram_raddr = TOP_IDX - drawn_q;
        mdsd_pkg::KIND_READ:    ram_raddr = read_index_i;
        default:                ram_raddr = '0;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    reload_d   = reload_q;
    shuf_idx_d = shuf_idx_q;
    drawn_d    = drawn_q;
    fill_d     = fill_q;
    rank_d     = rank_q;
    suit_d     = suit_q;
    dvd_d      = dvd_q;
    dvs_d      = dvs_q;
    rem_d      = rem_q;
    bit_d      = bit_q;
    card_a_d   = card_a_q;
    done_d     = 1'b0;
    card_d     = card_q;
    pos_d      = pos_q;
    stat_d     = stat_q;
    ram_we     = 1'b0;
    ram_waddr  = rem_q;
    ram_wdata  = card_a_q;

    unique case (state_q)
      mdsd_pkg::S_IDLE: begin
        if (accept) begin
          kind_d = mdsd_pkg::kind_e'(kind_i);
          dvd_d  = random_value_i;
          rem_d  = '0;
          bit_d  = '0;
          card_d = '0;
          pos_d  = '0;
          stat_d = mdsd_pkg::ST_OK;
          unique case (mdsd_pkg::kind_e'(kind_i))
            mdsd_pkg::KIND_RELOAD: begin
              reload_d   = 1'b1;
              fill_d     = '0;
              rank_d     = mdsd_pkg::RANK_FIRST;
              suit_d     = '0;
              shuf_idx_d = TOP_IDX;
              drawn_d    = '0;
              state_d    = mdsd_pkg::S_FILL;
            end
            mdsd_pkg::KIND_SHUFFLE: begin
              if ((shuf_idx_q == '0) || (shuf_idx_q >= TOTAL)) begin
                stat_d = mdsd_pkg::ST_SHUFFLE_DONE;
                done_d = 1'b1;
              end else begin
                dvs_d   = shuf_idx_q + 1'b1;
                state_d = mdsd_pkg::S_DIV;
              end
            end
            mdsd_pkg::KIND_DRAW: begin
              priority if (drawn_q >= TOTAL) begin
                stat_d = mdsd_pkg::ST_EXHAUSTED;
                done_d = 1'b1;
              end else if (drawn_q >= {1'b0, limit_q}) begin
                stat_d = mdsd_pkg::ST_LIMIT;
                done_d = 1'b1;
              end else begin
                dvs_d   = TOTAL - drawn_q;
                state_d = mdsd_pkg::S_DIV;
              end
            end
            default: begin
              if (read_index_i >= TOTAL) begin
                stat_d = mdsd_pkg::ST_BAD_INDEX;
                done_d = 1'b1;
              end else begin
                state_d = mdsd_pkg::S_RDOUT;
              end
            end
          endcase
        end
      end

      // write the ordered pattern one slot per cycle
      mdsd_pkg::S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_q;
        ram_wdata = {suit_q, rank_q};
        fill_d    = fill_q + 1'b1;
        if (rank_q == mdsd_pkg::RANK_LAST) begin
          rank_d = mdsd_pkg::RANK_FIRST;
          suit_d = suit_q + 1'b1;
        end else begin
          rank_d = rank_q + 1'b1;
        end
        if (fill_q == TOP_IDX) begin
          state_d  = mdsd_pkg::S_IDLE;
          reload_d = 1'b0;
          done_d   = reload_q;
        end
      end

      // random value modulo divisor, msb first
      mdsd_pkg::S_DIV: begin
        if (bit_q == '0) begin
          card_a_d = ram_rdata;
        end
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = trial_sub[IW-1:0];
        end else begin
          rem_d = trial[IW-1:0];
        end
        dvd_d = {dvd_q[RW-2:0], 1'b0};
        bit_d = bit_q + 1'b1;
        if (bit_q == LAST_BIT) begin
          state_d = mdsd_pkg::S_RDB;
        end
      end

      // fetch the chosen slot
      mdsd_pkg::S_RDB: begin
        state_d = mdsd_pkg::S_WR1;
      end

      mdsd_pkg::S_WR1: begin
        ram_we = 1'b1;
        if (kind_q == mdsd_pkg::KIND_SHUFFLE) begin
          // top slot takes the chosen card
          ram_waddr = shuf_idx_q;
          ram_wdata = ram_rdata;
          state_d   = mdsd_pkg::S_WR2;
        end else begin
          // chosen slot takes the last remaining card
          ram_waddr = rem_q;
          ram_wdata = card_a_q;
          card_d    = ram_rdata;
          pos_d     = rem_q;
          drawn_d   = drawn_q + 1'b1;
          done_d    = 1'b1;
          state_d   = mdsd_pkg::S_IDLE;
        end
      end

      // chosen slot takes the old top card
      mdsd_pkg::S_WR2: begin
        ram_we     = 1'b1;
        ram_waddr  = rem_q;
        ram_wdata  = card_a_q;
        pos_d      = rem_q;
        shuf_idx_d = shuf_idx_q - 1'b1;
        done_d     = 1'b1;
        state_d    = mdsd_pkg::S_IDLE;
      end

      mdsd_pkg::S_RDOUT: begin
        card_d  = ram_rdata;
        done_d  = 1'b1;
        state_d = mdsd_pkg::S_IDLE;
      end

      default: begin
        state_d = mdsd_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mdsd_pkg::S_FILL;
      kind_q     <= mdsd_pkg::KIND_RELOAD;
      reload_q   <= 1'b0;
      shuf_idx_q <= TOP_IDX;
      drawn_q    <= '0;
      fill_q     <= '0;
      rank_q     <= mdsd_pkg::RANK_FIRST;
      suit_q     <= '0;
      bit_q      <= '0;
      done_q     <= 1'b0;
      limit_q    <= mdsd_pkg::DEAL_LIMIT_RST;
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      reload_q   <= reload_d;
      shuf_idx_q <= shuf_idx_d;
      drawn_q    <= drawn_d;
      fill_q     <= fill_d;
      rank_q     <= rank_d;
      suit_q     <= suit_d;
      bit_q      <= bit_d;
      done_q     <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    card_a_q <= card_a_d;
    card_q   <= card_d;
    pos_q    <= pos_d;
    stat_q   <= stat_d;
  end

`ifndef SYNTH
  // every accepted request either responds next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted request neither answered nor in progress");

  // a result is only shown once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  // the card ram is never written while idle
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mdsd_pkg::S_IDLE) |-> !ram_we)
    else $error("card ram written while idle");

  // draws never run past the store and the shuffle pointer stays inside it
  a_counts_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drawn_q <= TOTAL) && (shuf_idx_q < TOTAL))
    else $error("draw count or shuffle index out of range");
`endif

endmodule

// ===== dv/tb_multi_deck_shuffle_and_draw.sv =====
// self-checking testbench for the multi-deck shuffle and draw block
module tb_multi_deck_shuffle_and_draw;

  localparam int CARD_W      = mdsd_pkg::CARD_W;
  localparam int IDX_W       = mdsd_pkg::IDX_W;
  localparam int RAND_W      = mdsd_pkg::RAND_W;
  localparam int KIND_W      = mdsd_pkg::KIND_W;
  localparam int STAT_W      = mdsd_pkg::STAT_W;
  localparam int LIM_W       = mdsd_pkg::LIM_W;
  localparam int DECKS       = 8;
  localparam int SHOE_CARDS  = mdsd_pkg::DECK_CARDS * DECKS;
  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;

  // one result as the block reports it
  typedef struct packed {
    logic [CARD_W-1:0] card;
    logic [IDX_W-1:0]  pos;
    mdsd_pkg::status_e status;
  } deal_result_t;

  // one line of the directed stimulus; hand-typed results where obvious
  typedef struct {
    bit                limit_write;
    mdsd_pkg::kind_e   kind;
    logic [RAND_W-1:0] rnd;
    logic [IDX_W-1:0]  ridx;
    bit                typed;
    logic [CARD_W-1:0] card;
    logic [IDX_W-1:0]  pos;
    mdsd_pkg::status_e status;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   kind_i = '0;
  logic [RAND_W-1:0]   random_value_i = '0;
  logic [IDX_W-1:0]    read_index_i = '0;
  logic                done_o;
  logic [CARD_W-1:0]   card_o;
  logic [IDX_W-1:0]    position_o;
  logic [STAT_W-1:0]   status_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LIM_W-1:0]    cfg_data_i = '0;

  // predictor copy of the shoe and its counters
  logic [CARD_W-1:0]   shoe_model [SHOE_CARDS];
  int unsigned         shuffle_top;
  int unsigned         dealt;
  int unsigned         limit_model;

  deal_result_t        pending_deals [$];
  int                  mismatches = 0;
  int                  cycles = 0;
  int                  requests_sent [4];
  int                  statuses_seen [5];

  multi_deck_shuffle_and_draw #(
    .DECK_COUNT (DECKS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .random_value_i (random_value_i),
    .read_index_i   (read_index_i),
    .done_o         (done_o),
    .card_o         (card_o),
    .position_o     (position_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // clock
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_multi_deck_shuffle_and_draw: errors");
      $finish;
    end
  end

  // ordered pattern: deck after deck, four suits of ranks one to thirteen
  function automatic void load_fresh_shoe();
    for (int p = 0; p < SHOE_CARDS; p++) begin
      shoe_model[p] = CARD_W'(((p / 13) % 4) * 16 + (p % 13) + 1);
    end
    shuffle_top = SHOE_CARDS - 1;
    dealt = 0;
  endfunction

  // expected outcome of one request, advancing the predictor state
  function automatic deal_result_t predict_deal(mdsd_pkg::kind_e k,
                                                logic [RAND_W-1:0] rnd,
                                                logic [IDX_W-1:0] ridx);
    deal_result_t r;
    int unsigned j;
    int unsigned remaining;
    logic [CARD_W-1:0] held;
    r.card = '0;
    r.pos = '0;
    r.status = mdsd_pkg::ST_OK;
    case (k)
      mdsd_pkg::KIND_RELOAD: begin
        load_fresh_shoe();
      end
      mdsd_pkg::KIND_SHUFFLE: begin
        if (shuffle_top == 0 || shuffle_top >= SHOE_CARDS) begin
          r.status = mdsd_pkg::ST_SHUFFLE_DONE;
        end else begin
          j = int'(rnd) % (shuffle_top + 1);
          held = shoe_model[shuffle_top];
          shoe_model[shuffle_top] = shoe_model[j];
          shoe_model[j] = held;
          r.pos = IDX_W'(j);
          shuffle_top = shuffle_top - 1;
        end
      end
      mdsd_pkg::KIND_DRAW: begin
        // exhaustion is checked ahead of the deal limit
        if (dealt >= SHOE_CARDS) begin
          r.status = mdsd_pkg::ST_EXHAUSTED;
        end else if (dealt >= limit_model) begin
          r.status = mdsd_pkg::ST_LIMIT;
        end else begin
          remaining = SHOE_CARDS - dealt;
          j = int'(rnd) % remaining;
          r.card = shoe_model[j];
          shoe_model[j] = shoe_model[remaining - 1];
          r.pos = IDX_W'(j);
          dealt = dealt + 1;
        end
      end
      default: begin
        if (ridx >= SHOE_CARDS) r.status = mdsd_pkg::ST_BAD_INDEX;
        else r.card = shoe_model[ridx];
      end
    endcase
    return r;
  endfunction

  // present one request and hold it until accepted; returns at the following falling edge
  task automatic issue(input mdsd_pkg::kind_e k, input logic [RAND_W-1:0] rnd,
                       input logic [IDX_W-1:0] ridx, input int gap,
                       input bit hand, input deal_result_t hand_res);
    deal_result_t r;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i = k;
    random_value_i = rnd;
    read_index_i = ridx;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    r = predict_deal(k, rnd, ridx);
    pending_deals.push_back(hand ? hand_res : r);
    requests_sent[int'(k)]++;
    @(negedge clk_i);
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_drain();
    start = 1'b0;
    while (pending_deals.size() != 0) @(negedge clk_i);
  endtask

  // deal limit write, only with the block idle
  task automatic set_deal_limit(input logic [LIM_W-1:0] value);
    wait_drain();
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_model = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic int pick_gap(int idle_pct);
    if (int'($urandom_range(0, 99)) < idle_pct) return int'($urandom_range(1, 6));
    return 0;
  endfunction

  // random value: mostly full width, some small, some at the extremes, some near the shuffle top
  function automatic logic [RAND_W-1:0] pick_random();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return RAND_W'($urandom());
    if (roll < 85) return RAND_W'($urandom_range(0, 600));
    if (roll < 90) return '0;
    if (roll < 95) return '1;
    return RAND_W'(shuffle_top + $urandom_range(0, 1));
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 85) return IDX_W'($urandom_range(0, SHOE_CARDS - 1));
    return IDX_W'($urandom_range(SHOE_CARDS, 511));
  endfunction

  // reload, then shuffle right through and past the end of the pass
  task automatic shuffle_whole_shoe(input int idle_pct);
    issue(mdsd_pkg::KIND_RELOAD, pick_random(), pick_index(), pick_gap(idle_pct), 1'b0, '0);
    for (int n = 0; n < SHOE_CARDS + 4; n++) begin
      issue(mdsd_pkg::KIND_SHUFFLE, pick_random(), pick_index(), pick_gap(idle_pct),
            1'b0, '0);
    end
  endtask

  // random requests from a fresh shoe; occasional pause until all results are back
  task automatic run_phase(input int count, input int reload_pct, input int draw_pct,
                           input int idle_pct);
    int unsigned roll;
    mdsd_pkg::kind_e k;
    issue(mdsd_pkg::KIND_RELOAD, pick_random(), pick_index(), pick_gap(idle_pct), 1'b0, '0);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < reload_pct) k = mdsd_pkg::KIND_RELOAD;
      else if (roll < reload_pct + draw_pct) k = mdsd_pkg::KIND_DRAW;
      else if ($urandom_range(0, 1) == 0) k = mdsd_pkg::KIND_SHUFFLE;
      else k = mdsd_pkg::KIND_READ;
      issue(k, pick_random(), pick_index(), pick_gap(idle_pct), 1'b0, '0);
      if ($urandom_range(0, 99) == 0) wait_drain();
    end
  endtask

  // directed requests: after reset, extremes, swaps, stale slot, deal limit
  plan_row_t plan [] = '{
    '{0, mdsd_pkg::KIND_READ,    31'd0,         9'd0,   1, 6'h01, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_READ,    31'd0,         9'd39,  1, 6'h31, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_READ,    31'd0,         9'd415, 1, 6'h3D, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_READ,    31'd0,         9'd416, 1, 6'h00, 9'd0,
      mdsd_pkg::ST_BAD_INDEX},
    '{0, mdsd_pkg::KIND_READ,    31'h7FFF_FFFF, 9'd511, 1, 6'h00, 9'd0,
      mdsd_pkg::ST_BAD_INDEX},
    '{0, mdsd_pkg::KIND_READ,    31'd0,         9'd13,  1, 6'h11, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_SHUFFLE, 31'd0,         9'd0,   1, 6'h00, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_READ,    31'd0,         9'd0,   1, 6'h3D, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_READ,    31'd0,         9'd415, 1, 6'h01, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_SHUFFLE, 31'h7FFF_FFFF, 9'd0,   0, 6'h00, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_SHUFFLE, 31'd413,       9'd0,   1, 6'h00, 9'd413, mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_DRAW,    31'd0,         9'd0,   1, 6'h3D, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_READ,    31'd0,         9'd415, 1, 6'h01, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_DRAW,    31'h7FFF_FFFF, 9'd0,   0, 6'h00, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_READ,    31'd0,         9'd0,   0, 6'h00, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_RELOAD,  31'h7FFF_FFFF, 9'd511, 1, 6'h00, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_READ,    31'd0,         9'd415, 1, 6'h3D, 9'd0,   mdsd_pkg::ST_OK},
    '{1, mdsd_pkg::KIND_READ,    31'd1,         9'd0,   0, 6'h00, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_DRAW,    31'd5,         9'd0,   1, 6'h06, 9'd5,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_DRAW,    31'd1,         9'd0,   1, 6'h00, 9'd0,   mdsd_pkg::ST_LIMIT},
    '{1, mdsd_pkg::KIND_READ,    31'd0,         9'd0,   0, 6'h00, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_RELOAD,  31'd0,         9'd0,   1, 6'h00, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_DRAW,    31'd0,         9'd0,   1, 6'h00, 9'd0,   mdsd_pkg::ST_LIMIT},
    '{1, mdsd_pkg::KIND_READ,    31'd255,       9'd0,   0, 6'h00, 9'd0,   mdsd_pkg::ST_OK},
    '{0, mdsd_pkg::KIND_SHUFFLE, 31'h5555_5555, 9'd0,   0, 6'h00, 9'd0,   mdsd_pkg::ST_OK}
  };

  // result checker: every strobe against the oldest expectation
  always @(posedge clk_i) begin
    deal_result_t want;
    if (rst_ni && done_o) begin
      if (pending_deals.size() == 0) begin
        $error("result with no request outstanding: card %0h position %0d status %0d",
               card_o, position_o, status_o);
        mismatches++;
      end else begin
        want = pending_deals.pop_front();
        if (card_o !== want.card) begin
          $error("card: expected %0h, actual %0h", want.card, card_o);
          mismatches++;
        end
        if (position_o !== want.pos) begin
          $error("position: expected %0d, actual %0d", want.pos, position_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatches++;
        end
        if (int'(want.status) < 5) statuses_seen[int'(want.status)]++;
      end
    end
  end

  // stimulus
  initial begin
    limit_model = mdsd_pkg::DEAL_LIMIT_RST;
    load_fresh_shoe();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // the shoe is written out after reset before the first request
    do @(negedge clk_i); while (busy);

    foreach (plan[n]) begin
      if (plan[n].limit_write) begin
        set_deal_limit(LIM_W'(plan[n].rnd));
      end else begin
        issue(plan[n].kind, plan[n].rnd, plan[n].ridx, 0, plan[n].typed,
              '{card: plan[n].card, pos: plan[n].pos, status: plan[n].status});
      end
    end

    // full pass down to a completed shuffle, then mixed traffic
    set_deal_limit(8'd255);
    shuffle_whole_shoe(0);
    run_phase(110, 2, 33, 0);
    set_deal_limit(8'd1);
    run_phase(130, 8, 33, 50);
    set_deal_limit(LIM_W'($urandom_range(2, 254)));
    run_phase(130, 3, 40, 9);
    set_deal_limit(8'd0);
    run_phase(90, 3, 33, 0);
    // draw-heavy with the top limit so the limit is reached
    set_deal_limit(8'd255);
    run_phase(300, 0, 92, 50);
    set_deal_limit(LIM_W'($urandom_range(1, 254)));
    run_phase(140, 3, 33, 9);
    set_deal_limit(8'd255);
    shuffle_whole_shoe(50);
    run_phase(79, 2, 40, 0);

    // drain, then watch for stray strobes
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (pending_deals.size() != 0) begin
      $error("%0d results never arrived", pending_deals.size());
      mismatches++;
    end

    $display("requests: reload %0d, shuffle %0d, draw %0d, read %0d over %0d cycles",
             requests_sent[0], requests_sent[1], requests_sent[2], requests_sent[3],
             cycles);
    $display("results: ok %0d, shuffle done %0d, limit %0d, bad index %0d",
             statuses_seen[0], statuses_seen[1], statuses_seen[3], statuses_seen[4]);
    if (mismatches == 0) begin
      $display("tb_multi_deck_shuffle_and_draw: clean");
    end else begin
      $display("tb_multi_deck_shuffle_and_draw: errors");
    end
    $finish;
  end

endmodule
